[design/smsg_pkg.sv]
// shared types, constants and codes for the sonar median speed governor
// no dependencies; used by every module of the block by scoped names

package smsg_pkg;

	// window geometry
	localparam int WINDOW  = 7;
	localparam int IDX_W   = $clog2(WINDOW);
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int MED_POS = WINDOW / 2;
	localparam int DIST_W  = 8;

	// configuration port
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = 2;
	localparam int DATA_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_SLOW_MARGIN = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FAST_MARGIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 2'd2;

	localparam logic [7:0] RST_SLOW_MARGIN = 8'd20;
	localparam logic [7:0] RST_FAST_MARGIN = 8'd40;
	localparam logic [6:0] RST_MAX_SPEED   = 7'd50;
	localparam logic [6:0] SPEED_CAP       = 7'd100;

	// command codes
	localparam logic [7:0] DIR_REVERSE = 8'd1;
	localparam logic [7:0] SPEED_SLOW  = 8'd2;
	localparam logic [7:0] BTN_STOP    = 8'd1;
	localparam logic [7:0] BTN_MODE    = 8'd2;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_SAMPLE  = 1'b1;

	typedef logic [DIST_W-1:0] dist_t;
	typedef dist_t [WINDOW-1:0] win_t;

	typedef enum logic {
		ST_IDLE,
		ST_MEDIAN
	} state_t;

	// median unit control and status
	typedef struct packed {
		logic start;
		logic sel_front;
	} med_ctrl_t;

	typedef struct packed {
		logic  done;
		dist_t median;
	} med_stat_t;

	// one result beat
	typedef struct packed {
		logic signed [7:0] drive_speed;
		logic              avoid_enabled;
		logic              speed_updated;
	} res_t;

endpackage

[design/smsg_window.sv]
// front and back sonar sample windows as shift lines, with the fill position
// depends on smsg_pkg

module smsg_window (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift_en,
	input  smsg_pkg::dist_t         front,
	input  smsg_pkg::dist_t         back,
	output smsg_pkg::win_t          front_w,
	output smsg_pkg::win_t          back_w,
	output logic                    last_slot
);

	logic [smsg_pkg::IDX_W-1:0] count_q;
	smsg_pkg::win_t             front_q;
	smsg_pkg::win_t             back_q;

	// fill position, wraps after the last slot of a window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift_en) begin
			if (last_slot) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + smsg_pkg::IDX_W'(1);
			end
		end
	end

	// sample shift lines, payload only
	always_ff @(posedge clk) begin
		if (shift_en) begin
			front_q[0] <= front;
			back_q[0]  <= back;
			for (int i = 1; i < smsg_pkg::WINDOW; i++) begin
				front_q[i] <= front_q[i-1];
				back_q[i]  <= back_q[i-1];
			end
		end
	end

	assign last_slot = (count_q == smsg_pkg::IDX_W'(smsg_pkg::WINDOW - 1));
	assign front_w   = front_q;
	assign back_w    = back_q;

endmodule

[design/smsg_median_sel.sv]
// iterative median selector: one candidate per cycle against a shared compare bank
// depends on smsg_pkg

module smsg_median_sel (
	input  logic                clk,
	input  logic                arst_n,
	input  smsg_pkg::med_ctrl_t ctrl,
	input  smsg_pkg::win_t      front_w,
	input  smsg_pkg::win_t      back_w,
	output smsg_pkg::med_stat_t stat
);

	logic                       running_q;
	logic                       done_q;
	logic                       sel_front_q;
	logic [smsg_pkg::IDX_W-1:0] idx_q;
	smsg_pkg::dist_t            median_q;

	smsg_pkg::win_t             sel_w;
	smsg_pkg::dist_t            cand;
	logic [smsg_pkg::CNT_W-1:0] gt_cnt;
	logic [smsg_pkg::CNT_W-1:0] ge_cnt;
	logic                       hit;
	logic                       last_idx;

	// shared compare bank: rank the current candidate
	always_comb begin
		sel_w  = sel_front_q ? front_w : back_w;
		cand   = sel_w[idx_q];
		gt_cnt = '0;
		ge_cnt = '0;
		for (int j = 0; j < smsg_pkg::WINDOW; j++) begin
			gt_cnt = gt_cnt + smsg_pkg::CNT_W'(sel_w[j] > cand);
			ge_cnt = ge_cnt + smsg_pkg::CNT_W'(sel_w[j] >= cand);
		end
		hit      = (gt_cnt <= smsg_pkg::CNT_W'(smsg_pkg::MED_POS))
			&& (ge_cnt > smsg_pkg::CNT_W'(smsg_pkg::MED_POS));
		last_idx = (idx_q == smsg_pkg::IDX_W'(smsg_pkg::WINDOW - 1));
	end

	// candidate sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			done_q      <= 1'b0;
			sel_front_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			done_q <= running_q && last_idx;
			if (ctrl.start) begin
				running_q   <= 1'b1;
				sel_front_q <= ctrl.sel_front;
				idx_q       <= '0;
			end else if (running_q) begin
				if (last_idx) begin
					running_q <= 1'b0;
				end else begin
					idx_q <= idx_q + smsg_pkg::IDX_W'(1);
				end
			end
		end
	end

	// latch the candidate holding the median rank
	always_ff @(posedge clk) begin
		if (running_q && hit) begin
			median_q <= cand;
		end
	end

	assign stat.done   = done_q;
	assign stat.median = median_q;

endmodule

[design/sonar_median_speed_governor_unit.sv]
// top level of the sonar median speed governor: control state, speed rule,
// configuration registers and result queue; depends on smsg_pkg,
// smsg_window and smsg_median_sel

// A command beat, or a sample beat that does not close a window, is taken and its
// result is registered in the output register, or in the holding register while the
// output is stalled. A sample beat that closes a window (stop button not held)
// starts a median scan that ranks one stored sample per cycle against the whole
// window. The input is stalled while the scan runs, and the speed result is
// registered when the median unit reports done. The output register plus one
// holding register let the next item be taken while one result still waits.
// Configuration writes complete in the APB access cycle; pready is always high.

module sonar_median_speed_governor_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smsg_pkg::ADDR_W-1:0]   paddr,
	input  logic [smsg_pkg::DATA_W-1:0]   pwdata,
	output logic [smsg_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          opcode,
	input  logic [7:0]                    direction_code,
	input  logic [7:0]                    speed_code,
	input  logic [7:0]                    button_code,
	input  logic [7:0]                    front_distance,
	input  logic [7:0]                    back_distance,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [7:0]             drive_speed,
	output logic                          avoid_enabled,
	output logic                          speed_updated
);

	// configuration registers
	logic [7:0] slow_margin_q;
	logic [7:0] fast_margin_q;
	logic [6:0] max_speed_q;

	// governor state
	smsg_pkg::state_t  state_q, state_d;
	logic              reverse_q, reverse_d;
	logic              slow_q, slow_d;
	logic              avoid_q, avoid_d;
	logic [7:0]        last_btn_q, last_btn_d;
	logic signed [7:0] target_q, target_d;

	// result queue
	logic           out_valid_q;
	logic           hold_valid_q;
	smsg_pkg::res_t out_q;
	smsg_pkg::res_t hold_q;
	smsg_pkg::res_t res_new;
	logic           res_en;

	logic                accept;
	logic                shift_en;
	logic                last_slot;
	logic                take;
	smsg_pkg::win_t      front_w;
	smsg_pkg::win_t      back_w;
	smsg_pkg::med_ctrl_t med_ctrl;
	smsg_pkg::med_stat_t med_stat;

	// speed rule
	logic [6:0]        cap;
	logic [7:0]        margin;
	logic signed [8:0] diff;
	logic [6:0]        mag;
	logic [6:0]        mag_h;
	logic [7:0]        mag8;
	logic signed [7:0] rule_speed;

	logic                              cfg_wr;
	logic [smsg_pkg::REG_IDX_W-1:0]    reg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[smsg_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_margin_q <= smsg_pkg::RST_SLOW_MARGIN;
			fast_margin_q <= smsg_pkg::RST_FAST_MARGIN;
			max_speed_q   <= smsg_pkg::RST_MAX_SPEED;
		end else if (cfg_wr) begin
			case (reg_idx)
				smsg_pkg::REG_SLOW_MARGIN: slow_margin_q <= pwdata[7:0];
				smsg_pkg::REG_FAST_MARGIN: fast_margin_q <= pwdata[7:0];
				smsg_pkg::REG_MAX_SPEED:   max_speed_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			smsg_pkg::REG_SLOW_MARGIN: prdata = {24'd0, slow_margin_q};
			smsg_pkg::REG_FAST_MARGIN: prdata = {24'd0, fast_margin_q};
			smsg_pkg::REG_MAX_SPEED:   prdata = {25'd0, max_speed_q};
			default:                   prdata = '0;
		endcase
	end

	// windows and median unit
	assign item_stall = (state_q != smsg_pkg::ST_IDLE) || hold_valid_q;
	assign accept     = item_valid && !item_stall;
	assign shift_en   = accept && (opcode == smsg_pkg::OP_SAMPLE);

	smsg_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (shift_en),
		.front     (front_distance),
		.back      (back_distance),
		.front_w   (front_w),
		.back_w    (back_w),
		.last_slot (last_slot)
	);

	smsg_median_sel u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (med_ctrl),
		.front_w (front_w),
		.back_w  (back_w),
		.stat    (med_stat)
	);

	// speed from the median in avoid mode, else the cap: margin, clamp, halve, sign
	always_comb begin
		cap    = (max_speed_q > smsg_pkg::SPEED_CAP) ? smsg_pkg::SPEED_CAP : max_speed_q;
		margin = slow_q ? slow_margin_q : fast_margin_q;
		diff   = $signed({1'b0, med_stat.median}) - $signed({1'b0, margin});
		if (avoid_q) begin
			if (diff < 0) begin
				mag = '0;
			end else if (diff > $signed({2'b00, cap})) begin
				mag = cap;
			end else begin
				mag = diff[6:0];
			end
		end else begin
			mag = cap;
		end
		mag_h      = slow_q ? (mag >> 1) : mag;
		mag8       = {1'b0, mag_h};
		rule_speed = reverse_q ? $signed(~mag8 + 8'd1) : $signed(mag8);
	end

	// sequencer: next state and result
	always_comb begin
		state_d    = state_q;
		reverse_d  = reverse_q;
		slow_d     = slow_q;
		avoid_d    = avoid_q;
		last_btn_d = last_btn_q;
		target_d   = target_q;
		res_en     = 1'b0;
		res_new.speed_updated = 1'b0;
		med_ctrl.start     = 1'b0;
		med_ctrl.sel_front = reverse_q;
		case (state_q)
			smsg_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == smsg_pkg::OP_COMMAND) begin
						reverse_d = (direction_code == smsg_pkg::DIR_REVERSE);
						slow_d    = (speed_code == smsg_pkg::SPEED_SLOW);
						if (button_code == smsg_pkg::BTN_STOP) begin
							target_d = '0;
							res_new.speed_updated = 1'b1;
						end
						if (last_btn_q != smsg_pkg::BTN_MODE
							&& button_code == smsg_pkg::BTN_MODE) begin
							avoid_d = !avoid_q;
						end
						last_btn_d = button_code;
						res_en     = 1'b1;
					end else if (last_slot && last_btn_q != smsg_pkg::BTN_STOP) begin
						med_ctrl.start = 1'b1;
						state_d        = smsg_pkg::ST_MEDIAN;
					end else begin
						res_en = 1'b1;
					end
				end
			end
			smsg_pkg::ST_MEDIAN: begin
				if (med_stat.done) begin
					target_d = rule_speed;
					res_new.speed_updated = 1'b1;
					res_en   = 1'b1;
					state_d  = smsg_pkg::ST_IDLE;
				end
			end
			default: state_d = smsg_pkg::ST_IDLE;
		endcase
		res_new.drive_speed   = target_d;
		res_new.avoid_enabled = avoid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= smsg_pkg::ST_IDLE;
			reverse_q  <= 1'b0;
			slow_q     <= 1'b0;
			avoid_q    <= 1'b0;
			last_btn_q <= '0;
			target_q   <= '0;
		end else begin
			state_q    <= state_d;
			reverse_q  <= reverse_d;
			slow_q     <= slow_d;
			avoid_q    <= avoid_d;
			last_btn_q <= last_btn_d;
			target_q   <= target_d;
		end
	end

	// result queue: output register backed by one holding register
	assign take = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= res_en;
			end else begin
				out_valid_q <= res_en;
			end
		end else if (res_en) begin
			hold_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			if (hold_valid_q) begin
				out_q <= hold_q;
				if (res_en) begin
					hold_q <= res_new;
				end
			end else if (res_en) begin
				out_q <= res_new;
			end
		end else if (res_en) begin
			hold_q <= res_new;
		end
	end

	assign result_valid  = out_valid_q;
	assign drive_speed   = out_q.drive_speed;
	assign avoid_enabled = out_q.avoid_enabled;
	assign speed_updated = out_q.speed_updated;

	// checks
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		med_stat.done |-> state_q == smsg_pkg::ST_MEDIAN)
		else $error("median done outside the scan");

	a_scan_length: assert property (@(posedge clk) disable iff (!arst_n)
		med_ctrl.start |-> ##(smsg_pkg::WINDOW + 1) med_stat.done)
		else $error("median scan length wrong");

	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("holding register full with output register empty");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		res_en |-> !hold_valid_q)
		else $error("new result with holding register full");

endmodule

[tb/speed_governor_checker.sv]
// result checker for the sonar median speed governor: watches the register port and
// both beat channels, predicts each result beat and compares it; depends on smsg_pkg

module speed_governor_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	// register port, watched for writes
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [smsg_pkg::ADDR_W-1:0] paddr,
	input  logic [smsg_pkg::DATA_W-1:0] pwdata,
	input  logic                        pready,
	// item channel
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  logic                        opcode,
	input  logic [7:0]                  direction_code,
	input  logic [7:0]                  speed_code,
	input  logic [7:0]                  button_code,
	input  logic [7:0]                  front_distance,
	input  logic [7:0]                  back_distance,
	// result channel
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic signed [7:0]           drive_speed,
	input  logic                        avoid_enabled,
	input  logic                        speed_updated,
	// status towards the test top
	output int                          fail_count,
	output int                          pending_count
);

	// own copy of the governor state and registers
	smsg_pkg::win_t front_hist;
	smsg_pkg::win_t back_hist;
	int             fill_count;
	logic           reverse_q;
	logic           slow_q;
	logic           avoid_q;
	logic [7:0]     last_button_q;
	int             target_q;
	logic [7:0]     slow_margin_q;
	logic [7:0]     fast_margin_q;
	logic [6:0]     max_speed_q;

	smsg_pkg::res_t expected_beats[$];
	int             mismatches;

	// descending rank, entry at the middle position
	function automatic int median_of(input smsg_pkg::win_t w);
		smsg_pkg::win_t  s;
		smsg_pkg::dist_t v;
		int              j;
		s = w;
		for (int i = 1; i < smsg_pkg::WINDOW; i++) begin
			v = s[i];
			j = i;
			while (j > 0 && s[j-1] < v) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = v;
		end
		return int'(s[smsg_pkg::MED_POS]);
	endfunction

	// advance the state by one item beat and queue the result it causes
	task automatic predict_speed(input logic op, input logic [7:0] dir, spd, btn, fd, bd);
		int             cap;
		int             v;
		logic           upd;
		smsg_pkg::res_t r;
		upd = 1'b0;
		if (op == smsg_pkg::OP_COMMAND) begin
			reverse_q = (dir == smsg_pkg::DIR_REVERSE);
			slow_q    = (spd == smsg_pkg::SPEED_SLOW);
			if (btn == smsg_pkg::BTN_STOP) begin
				target_q = 0;
				upd      = 1'b1;
			end
			// toggle only on a fresh press of the mode button
			if (last_button_q != smsg_pkg::BTN_MODE && btn == smsg_pkg::BTN_MODE)
				avoid_q = !avoid_q;
			last_button_q = btn;
		end else begin
			if (fill_count >= smsg_pkg::WINDOW)
				fill_count = 0;
			front_hist[fill_count] = fd;
			back_hist[fill_count]  = bd;
			fill_count++;
			if (fill_count >= smsg_pkg::WINDOW) begin
				fill_count = 0;
				// stop button held: window thrown away, speed kept
				if (last_button_q != smsg_pkg::BTN_STOP) begin
					cap = (max_speed_q > smsg_pkg::SPEED_CAP)
						? int'(smsg_pkg::SPEED_CAP) : int'(max_speed_q);
					if (avoid_q) begin
						// reversing looks at the front sonar, otherwise the back one
						v = reverse_q ? median_of(front_hist) : median_of(back_hist);
						v = v - (slow_q ? int'(slow_margin_q) : int'(fast_margin_q));
						if (v > cap)
							v = cap;
						if (v < 0)
							v = 0;
						if (reverse_q)
							v = -v;
					end else begin
						v = reverse_q ? -cap : cap;
					end
					// halve toward zero in slow mode
					if (slow_q)
						v = v / 2;
					target_q = v;
					upd      = 1'b1;
				end
			end
		end
		r.drive_speed   = target_q[7:0];
		r.avoid_enabled = avoid_q;
		r.speed_updated = upd;
		expected_beats.push_back(r);
	endtask

	// compare one accepted result beat with the oldest prediction
	task automatic check_result();
		smsg_pkg::res_t exp_r;
		if (expected_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: speed %0d avoid %0b updated %0b",
					drive_speed, avoid_enabled, speed_updated);
		end else begin
			exp_r = expected_beats.pop_front();
			if (exp_r.drive_speed !== drive_speed || exp_r.avoid_enabled !== avoid_enabled ||
					exp_r.speed_updated !== speed_updated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected speed %0d avoid %0b updated %0b, ",
						"got speed %0d avoid %0b updated %0b",
						exp_r.drive_speed, exp_r.avoid_enabled, exp_r.speed_updated,
						drive_speed, avoid_enabled, speed_updated);
			end
		end
	endtask

	// watch all channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_hist    = '0;
			back_hist     = '0;
			fill_count    = 0;
			reverse_q     = 1'b0;
			slow_q        = 1'b0;
			avoid_q       = 1'b0;
			last_button_q = 8'd0;
			target_q      = 0;
			slow_margin_q = smsg_pkg::RST_SLOW_MARGIN;
			fast_margin_q = smsg_pkg::RST_FAST_MARGIN;
			max_speed_q   = smsg_pkg::RST_MAX_SPEED;
			mismatches    = 0;
			expected_beats.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[smsg_pkg::ADDR_W-1:2])
					smsg_pkg::REG_SLOW_MARGIN: slow_margin_q = pwdata[7:0];
					smsg_pkg::REG_FAST_MARGIN: fast_margin_q = pwdata[7:0];
					smsg_pkg::REG_MAX_SPEED:   max_speed_q   = pwdata[6:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				predict_speed(opcode, direction_code, speed_code, button_code,
					front_distance, back_distance);
			if (result_valid && !result_stall)
				check_result();
			fail_count    <= mismatches;
			pending_count <= expected_beats.size();
		end
	end

endmodule

[tb/sonar_median_speed_governor_unit_test.sv]
// test top for the sonar median speed governor: clock, reset, register writes,
// item and result beat pacing, verdict; depends on smsg_pkg, the block and
// speed_governor_checker

module sonar_median_speed_governor_unit_test;

	localparam logic [7:0]                     DIR_FORWARD      = 8'd2;
	localparam logic [smsg_pkg::REG_IDX_W-1:0] REG_SPARE        = 2'd3;
	localparam int                             DRAIN_CYCLES     = smsg_pkg::WINDOW + 6;
	localparam int                             RANDOM_PER_PHASE = 310;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [smsg_pkg::ADDR_W-1:0] paddr;
	logic [smsg_pkg::DATA_W-1:0] pwdata;
	logic [smsg_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        item_valid;
	logic                        item_stall;
	logic                        opcode;
	logic [7:0]                  direction_code;
	logic [7:0]                  speed_code;
	logic [7:0]                  button_code;
	logic [7:0]                  front_distance;
	logic [7:0]                  back_distance;
	logic                        result_valid;
	logic                        result_stall;
	logic signed [7:0]           drive_speed;
	logic                        avoid_enabled;
	logic                        speed_updated;

	int                fail_count;
	int                pending_count;
	bit                calm;

	sonar_median_speed_governor_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.direction_code (direction_code),
		.speed_code     (speed_code),
		.button_code    (button_code),
		.front_distance (front_distance),
		.back_distance  (back_distance),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.drive_speed    (drive_speed),
		.avoid_enabled  (avoid_enabled),
		.speed_updated  (speed_updated)
	);

	speed_governor_checker governor_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.direction_code (direction_code),
		.speed_code     (speed_code),
		.button_code    (button_code),
		.front_distance (front_distance),
		.back_distance  (back_distance),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.drive_speed    (drive_speed),
		.avoid_enabled  (avoid_enabled),
		.speed_updated  (speed_updated),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// result side back-pressure
	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// one item beat, held until taken, then an optional gap
	task automatic send_item(input logic op, input logic [7:0] dir, spd, btn, fd, bd);
		int gap;
		opcode         <= op;
		direction_code <= dir;
		speed_code     <= spd;
		button_code    <= btn;
		front_distance <= fd;
		back_distance  <= bd;
		item_valid     <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mostly sample pairs so windows keep closing, with commands mixed in
	task automatic send_random_item();
		logic       op;
		logic [7:0] dir;
		logic [7:0] spd;
		logic [7:0] btn;
		logic [7:0] fd;
		logic [7:0] bd;
		int         r;
		op = ($urandom_range(0, 99) < 22) ? smsg_pkg::OP_COMMAND : smsg_pkg::OP_SAMPLE;
		case ($urandom_range(0, 3))
			0:       dir = smsg_pkg::DIR_REVERSE;
			1:       dir = DIR_FORWARD;
			default: dir = 8'($urandom());
		endcase
		spd = $urandom_range(0, 1) ? smsg_pkg::SPEED_SLOW : 8'($urandom());
		r = $urandom_range(0, 99);
		if (r < 8)
			btn = smsg_pkg::BTN_STOP;
		else if (r < 30)
			btn = smsg_pkg::BTN_MODE;
		else if (r < 45)
			btn = 8'($urandom());
		else
			btn = 8'd0;
		// distances near the margins as well as over the full range
		fd = $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 120));
		bd = $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 120));
		send_item(op, dir, spd, btn, fd, bd);
	endtask

	task automatic run_random(input int count, input bit quiet);
		for (int i = 0; i < count; i++) begin
			if (quiet)
				calm = 1'b1;
			else if (i % 64 == 0)
				calm = ($urandom_range(0, 4) == 0);
			send_random_item();
		end
		calm = 1'b0;
	endtask

	task automatic hold_items();
		item_valid <= 1'b0;
	endtask

	// wait for every result, then let the block settle
	task automatic wait_drained();
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup cycle, access cycle, done when pready
	task automatic write_reg(input logic [smsg_pkg::REG_IDX_W-1:0] idx,
		input logic [smsg_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		arst_n         = 1'b0;
		calm           = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		item_valid     = 1'b0;
		opcode         = smsg_pkg::OP_COMMAND;
		direction_code = 8'd0;
		speed_code     = 8'd0;
		button_code    = 8'd0;
		front_distance = 8'd0;
		back_distance  = 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers, avoid off: full forward speed
		send_item(smsg_pkg::OP_COMMAND, DIR_FORWARD, 8'd0, 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < smsg_pkg::WINDOW; i++)
			send_item(smsg_pkg::OP_SAMPLE, 8'hff, 8'hff, 8'hff, 8'(i * 42), 8'(255 - i * 42));
		// mode press while reversing slowly: front median, clamp, halve
		send_item(smsg_pkg::OP_COMMAND, smsg_pkg::DIR_REVERSE, smsg_pkg::SPEED_SLOW,
			smsg_pkg::BTN_MODE, 8'hff, 8'hff);
		for (int i = 0; i < smsg_pkg::WINDOW; i++)
			send_item(smsg_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'((i * 113 + 7) % 256),
				8'(255 - i * 37));
		// stop button with direction none, then a window thrown away while held
		send_item(smsg_pkg::OP_COMMAND, 8'd0, 8'hff, smsg_pkg::BTN_STOP, 8'd0, 8'd0);
		for (int i = 0; i < smsg_pkg::WINDOW; i++)
			send_item(smsg_pkg::OP_SAMPLE, 8'($urandom()), 8'($urandom()), 8'($urandom()),
				8'($urandom()), 8'($urandom()));
		// fresh mode press after the stop button toggles avoid off
		send_item(smsg_pkg::OP_COMMAND, 8'hff, 8'd1, smsg_pkg::BTN_MODE, 8'hff, 8'hff);
		run_random(RANDOM_PER_PHASE, 1'b0);
		hold_items();
		wait_drained();

		// zero margins, zero cap
		write_reg(smsg_pkg::REG_SLOW_MARGIN, 32'd0);
		write_reg(smsg_pkg::REG_FAST_MARGIN, 32'd0);
		write_reg(smsg_pkg::REG_MAX_SPEED, 32'd0);
		run_random(RANDOM_PER_PHASE, 1'b0);
		hold_items();
		wait_drained();

		// full margins, cap above the limit, a write to the unused slot
		write_reg(smsg_pkg::REG_SLOW_MARGIN, 32'hffff_ffff);
		write_reg(smsg_pkg::REG_FAST_MARGIN, 32'd255);
		write_reg(smsg_pkg::REG_MAX_SPEED, 32'hffff_ff7f);
		write_reg(REG_SPARE, $urandom());
		run_random(RANDOM_PER_PHASE, 1'b0);
		hold_items();
		wait_drained();

		// cap at the limit, sender pauses until every result is back
		write_reg(smsg_pkg::REG_MAX_SPEED, 32'd100);
		write_reg(smsg_pkg::REG_SLOW_MARGIN, $urandom_range(0, 60));
		write_reg(smsg_pkg::REG_FAST_MARGIN, $urandom_range(0, 120));
		run_random(RANDOM_PER_PHASE / 2, 1'b0);
		hold_items();
		wait_drained();
		run_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2, 1'b0);
		hold_items();
		wait_drained();

		// arbitrary register words
		write_reg(smsg_pkg::REG_SLOW_MARGIN, $urandom());
		write_reg(smsg_pkg::REG_FAST_MARGIN, $urandom());
		write_reg(smsg_pkg::REG_MAX_SPEED, $urandom());
		run_random(RANDOM_PER_PHASE, 1'b0);
		hold_items();
		wait_drained();

		// back to back, no idling on the item side
		write_reg(smsg_pkg::REG_SLOW_MARGIN, 32'd1);
		write_reg(smsg_pkg::REG_FAST_MARGIN, 32'd254);
		write_reg(smsg_pkg::REG_MAX_SPEED, 32'd101);
		run_random(RANDOM_PER_PHASE, 1'b1);
		hold_items();
		wait_drained();

		if (fail_count == 0 && pending_count == 0) begin
			$display("sonar_median_speed_governor_unit_test passed");
		end else begin
			$display("sonar_median_speed_governor_unit_test failed");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("sonar_median_speed_governor_unit_test failed");
		$finish;
	end

endmodule

[files.f]
design/smsg_pkg.sv
design/smsg_window.sv
design/smsg_median_sel.sv
design/sonar_median_speed_governor_unit.sv
tb/speed_governor_checker.sv
tb/sonar_median_speed_governor_unit_test.sv
